// File: hdl/negacyclic_monomial_multiply_macros.svh
// assertion macros shared by the monomial multiply modules
// expects clk and rst_n in the scope of each use
`ifndef NEGACYCLIC_MONOMIAL_MULTIPLY_MACROS_SVH
`define NEGACYCLIC_MONOMIAL_MULTIPLY_MACROS_SVH

// same-cycle implication
`define NMM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NMM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/nmm_pkg.sv
// shared types and constants of the negacyclic monomial multiply block
// no dependencies
package nmm_pkg;

  localparam int VALUE_W          = 62;
  localparam int IN_IDX_W         = 10;
  localparam int SHIFT_W          = 11;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 62;
  localparam int DEF_RING_DEGREE  = 1024;
  localparam int DEF_COEFF_BITS   = 62;
  localparam int DEF_QUEUE_DEPTH  = 2;
  localparam int DEF_IDX_W        = $clog2(DEF_RING_DEGREE);
  localparam int DEF_STORE_W      = (DEF_COEFF_BITS < VALUE_W) ? DEF_COEFF_BITS : VALUE_W;

  localparam logic [VALUE_W-1:0] MIN_MODULUS = VALUE_W'(2);

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MINUS_ONE = 2'd2;

  typedef struct packed {
    logic                cmd;
    logic [IN_IDX_W-1:0] coeff_index;
    logic [VALUE_W-1:0]  coeff_value;
  } in_item_t;

  typedef struct packed {
    logic [IN_IDX_W-1:0] result_index;
    logic [VALUE_W-1:0]  result_value;
  } out_item_t;

  // classified operation at the default sizes
  typedef struct packed {
    logic                   is_read;
    logic [DEF_IDX_W-1:0]   idx;
    logic [DEF_IDX_W-1:0]   pos;
    logic                   neg;
    logic [DEF_STORE_W-1:0] value;
  } op_default_t;

endpackage

// File: hdl/negacyclic_monomial_multiply.sv
// top level of the negacyclic monomial multiply block
// depends on nmm_pkg, nmm_front, nmm_queue and nmm_back
//
// Multiplies one residue polynomial mod X^N+1 and q by X^a, or by X^a - 1.
// Input channel (in_valid/in_ready/in_item): a load item writes coeff_value at
// coeff_index mod N into the coefficient store; a read item returns result
// coefficient coeff_index mod N on the output channel (out_valid/out_ready/out_item).
// Loads give no result. Items are handled in order, so a read sees every earlier load.
// Configuration (cfg_wr_en/cfg_index/cfg_data) takes modulus, shift and mode; a
// modulus below 2 acts as 2. It is to be written only while no item is in flight;
// the user must keep to this, as the block does not enforce it.
// Front: holds one item at a time, reducing its index and shift by restoring steps
// (none when N is 1024 or more). A two-entry queue parts front and back.
// Back: a load only writes the store; a read runs through store read, check of the
// stored value against q, term, and subtract into the output register, and in
// minus-one mode the check also covers the own coefficient. Each stored value not
// already below q is reduced by the bit-serial remainder unit.
// When the receiver stalls, the result waits in the output register and the
// front and queue keep taking items until the queue fills.
// Reset clears control state and sets modulus 2, shift 0, plain mode; the store
// content is undefined until loaded.

module negacyclic_monomial_multiply #(
  parameter int RING_DEGREE = nmm_pkg::DEF_RING_DEGREE,
  parameter int COEFF_BITS  = nmm_pkg::DEF_COEFF_BITS,
  parameter int QUEUE_DEPTH = nmm_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  nmm_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output nmm_pkg::out_item_t              out_item,
  input  logic                            cfg_wr_en,
  input  logic [nmm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nmm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W   = $clog2(RING_DEGREE);
  localparam int STORE_W = (COEFF_BITS < nmm_pkg::VALUE_W) ? COEFF_BITS : nmm_pkg::VALUE_W;

  typedef struct packed {
    logic               is_read;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   pos;
    logic               neg;
    logic [STORE_W-1:0] value;
  } op_t;

  logic [nmm_pkg::VALUE_W-1:0] modulus_r;
  logic [nmm_pkg::SHIFT_W-1:0] shift_r;
  logic                        minus_one_r;

  logic fq_valid;
  logic fq_ready;
  op_t  fq_op;
  logic qb_valid;
  logic qb_ready;
  op_t  qb_op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= nmm_pkg::MIN_MODULUS;
      shift_r     <= '0;
      minus_one_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        nmm_pkg::CFG_MODULUS: begin
          modulus_r <= (cfg_data[nmm_pkg::VALUE_W-1:0] < nmm_pkg::MIN_MODULUS) ?
                       nmm_pkg::MIN_MODULUS : cfg_data[nmm_pkg::VALUE_W-1:0];
        end
        nmm_pkg::CFG_SHIFT:     shift_r     <= cfg_data[nmm_pkg::SHIFT_W-1:0];
        nmm_pkg::CFG_MINUS_ONE: minus_one_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  nmm_front #(
    .RING_DEGREE (RING_DEGREE),
    .COEFF_BITS  (COEFF_BITS),
    .op_t        (op_t)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_item),
    .shift_amount (shift_r),
    .op_valid     (fq_valid),
    .op_ready     (fq_ready),
    .op           (fq_op)
  );

  nmm_queue #(
    .DEPTH (QUEUE_DEPTH),
    .op_t  (op_t)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_op    (fq_op),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_op     (qb_op)
  );

  nmm_back #(
    .RING_DEGREE (RING_DEGREE),
    .COEFF_BITS  (COEFF_BITS),
    .op_t        (op_t)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (qb_valid),
    .op_ready  (qb_ready),
    .op        (qb_op),
    .modulus   (modulus_r),
    .minus_one (minus_one_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// File: hdl/nmm_ram.sv
// generic ram, one write port and two registered read ports
// no dependencies beyond nmm_pkg defaults
module nmm_ram #(
  parameter int WIDTH = nmm_pkg::DEF_STORE_W,
  parameter int DEPTH = nmm_pkg::DEF_RING_DEGREE
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// File: hdl/nmm_front.sv
// front end: accepts items, reduces index and shift, classifies the source term
// depends on nmm_pkg and the assertion macros
`include "negacyclic_monomial_multiply_macros.svh"

module nmm_front #(
  parameter int  RING_DEGREE = nmm_pkg::DEF_RING_DEGREE,
  parameter int  COEFF_BITS  = nmm_pkg::DEF_COEFF_BITS,
  parameter type op_t        = nmm_pkg::op_default_t
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  nmm_pkg::in_item_t              in_item,
  input  logic [nmm_pkg::SHIFT_W-1:0]    shift_amount,
  output logic                           op_valid,
  input  logic                           op_ready,
  output op_t                            op
);

  localparam int IDX_W   = $clog2(RING_DEGREE);
  localparam int STORE_W = (COEFF_BITS < nmm_pkg::VALUE_W) ? COEFF_BITS : nmm_pkg::VALUE_W;
  localparam int LOG_N   = $clog2(RING_DEGREE + 1) - 1;
  localparam int STEPS   = (LOG_N < nmm_pkg::IN_IDX_W) ? nmm_pkg::IN_IDX_W - LOG_N : 0;
  localparam int TOP_K   = (STEPS > 0) ? STEPS - 1 : 0;
  localparam int N_SMALL = (STEPS > 0) ? RING_DEGREE : 0;
  localparam int CW      = nmm_pkg::SHIFT_W + 1;
  localparam int CNT_W   = $clog2(STEPS + 2);
  localparam int S_W     = IDX_W + 2;

  localparam logic [CW-1:0]    DN_TOP  = CW'(N_SMALL << TOP_K);
  localparam logic [CW-1:0]    D2N_TOP = CW'(N_SMALL << (TOP_K + 1));
  localparam logic [S_W-1:0]   N_S     = S_W'(RING_DEGREE);
  localparam logic [S_W-1:0]   TWO_N   = S_W'(2 * RING_DEGREE);

  logic                            busy_r;
  logic                            cmd_r;
  logic [CNT_W-1:0]                cnt_r;
  logic [nmm_pkg::IN_IDX_W-1:0]    vi_r;
  logic [nmm_pkg::SHIFT_W-1:0]     va_r;
  logic [STORE_W-1:0]              val_r;
  logic [CW-1:0]                   dn_r;
  logic [CW-1:0]                   d2n_r;

  logic                            push;
  logic                            step;
  logic [CW-1:0]                   vi_ext;
  logic [CW-1:0]                   va_ext;
  logic [CW-1:0]                   vi_sub;
  logic [CW-1:0]                   va_sub;
  logic [IDX_W+nmm_pkg::IN_IDX_W-1:0] idx_wide;
  logic [S_W+nmm_pkg::SHIFT_W-1:0] a_wide;
  logic [IDX_W-1:0]                idx_red;
  logic [S_W-1:0]                  a_red;
  logic [S_W-1:0]                  s_raw;
  logic [S_W-1:0]                  s_mod;
  logic [S_W-1:0]                  s_low;
  logic                            neg;

  assign op_valid = busy_r && (cnt_r == '0);
  assign push     = op_valid && op_ready;
  assign in_ready = !busy_r || push;
  assign step     = busy_r && (cnt_r != '0);

  // one restoring step on both values per cycle
  assign vi_ext = CW'(vi_r);
  assign va_ext = CW'(va_r);
  assign vi_sub = vi_ext - dn_r;
  assign va_sub = va_ext - d2n_r;

  // classify the source coefficient
  assign idx_wide = {{IDX_W{1'b0}}, vi_r};
  assign a_wide   = {{S_W{1'b0}}, va_r};
  assign idx_red  = idx_wide[IDX_W-1:0];
  assign a_red    = a_wide[S_W-1:0];
  assign s_raw    = S_W'(idx_red) + TWO_N - a_red;
  assign s_mod    = (s_raw >= TWO_N) ? s_raw - TWO_N : s_raw;
  assign neg      = (s_mod >= N_S);
  assign s_low    = neg ? s_mod - N_S : s_mod;

  always_comb begin
    op         = '0;
    op.is_read = (cmd_r == nmm_pkg::CMD_READ);
    op.idx     = idx_red;
    op.pos     = s_low[IDX_W-1:0];
    op.neg     = neg;
    op.value   = val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (in_valid && in_ready) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(STEPS);
    end else if (push) begin
      busy_r <= 1'b0;
    end else if (step) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_item.cmd;
      vi_r  <= in_item.coeff_index;
      va_r  <= shift_amount;
      val_r <= in_item.coeff_value[STORE_W-1:0];
      dn_r  <= DN_TOP;
      d2n_r <= D2N_TOP;
    end else if (step) begin
      if (vi_ext >= dn_r) begin
        vi_r <= vi_sub[nmm_pkg::IN_IDX_W-1:0];
      end
      if (va_ext >= d2n_r) begin
        va_r <= va_sub[nmm_pkg::SHIFT_W-1:0];
      end
      dn_r  <= dn_r >> 1;
      d2n_r <= d2n_r >> 1;
    end
  end

  `NMM_ASSERT_IMP(a_cnt_busy, cnt_r != '0, busy_r, "front step count set while idle")
  `NMM_ASSERT_NXT(a_push_frees, push && !(in_valid && in_ready), !busy_r,
                  "front still busy after handing off its item")
  `NMM_ASSERT_IMP(a_op_reduced, op_valid, s_low < N_S, "source position not below ring degree")

endmodule

// File: hdl/nmm_queue.sv
// short queue of classified operations between front and back
// depends on nmm_pkg and the assertion macros
`include "negacyclic_monomial_multiply_macros.svh"

module nmm_queue #(
  parameter int  DEPTH = nmm_pkg::DEF_QUEUE_DEPTH,
  parameter type op_t  = nmm_pkg::op_default_t
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_op,
  output logic pop_valid,
  input  logic pop_ready,
  output op_t  pop_op
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  op_t              slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_op     = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  `NMM_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "queue count beyond depth")
  `NMM_ASSERT_NXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1,
                  "queue count did not follow a push")
  `NMM_ASSERT_NXT(a_count_down, pop && !push, count_r == $past(count_r) - 1'b1,
                  "queue count did not follow a pop")

endmodule

// File: hdl/nmm_rem.sv
// iterative remainder unit, one dividend bit per cycle
// depends on nmm_pkg and the assertion macros
`include "negacyclic_monomial_multiply_macros.svh"

module nmm_rem #(
  parameter int COEFF_BITS = nmm_pkg::DEF_COEFF_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [((COEFF_BITS < nmm_pkg::VALUE_W) ? COEFF_BITS : nmm_pkg::VALUE_W)-1:0] dividend,
  input  logic [nmm_pkg::VALUE_W-1:0]         modulus,
  output logic                                busy,
  output logic                                done,
  output logic [nmm_pkg::VALUE_W-1:0]         result
);

  localparam int STORE_W = (COEFF_BITS < nmm_pkg::VALUE_W) ? COEFF_BITS : nmm_pkg::VALUE_W;
  localparam int VW      = nmm_pkg::VALUE_W;
  localparam int CNT_W   = $clog2(STORE_W + 1);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [VW-1:0]       rem_r;
  logic [STORE_W-1:0]  dv_r;
  logic [VW:0]         trial;
  logic [VW:0]         trial_sub;
  logic                fits;

  assign trial     = {rem_r, dv_r[STORE_W-1]};
  assign trial_sub = trial - {1'b0, modulus};
  assign fits      = (trial >= {1'b0, modulus});

  assign busy   = busy_r;
  assign done   = done_r;
  assign result = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STORE_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= '0;
      dv_r  <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? trial_sub[VW-1:0] : trial[VW-1:0];
      dv_r  <= dv_r << 1;
    end
  end

  `NMM_ASSERT_IMP(a_done_idle, done_r, !busy_r, "remainder done while still running")
  `NMM_ASSERT_IMP(a_rem_below, done_r, rem_r < modulus, "remainder not below modulus")
  `NMM_ASSERT_IMP(a_cnt_busy, cnt_r != '0, busy_r, "remainder count set while idle")

endmodule

// File: hdl/nmm_back.sv
// back end: coefficient store, reduction of stored values, modular term and subtract
// depends on nmm_pkg, nmm_ram, nmm_rem and the assertion macros
`include "negacyclic_monomial_multiply_macros.svh"

module nmm_back #(
  parameter int  RING_DEGREE = nmm_pkg::DEF_RING_DEGREE,
  parameter int  COEFF_BITS  = nmm_pkg::DEF_COEFF_BITS,
  parameter type op_t        = nmm_pkg::op_default_t
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        op_valid,
  output logic                        op_ready,
  input  op_t                         op,
  input  logic [nmm_pkg::VALUE_W-1:0] modulus,
  input  logic                        minus_one,
  output logic                        out_valid,
  input  logic                        out_ready,
  output nmm_pkg::out_item_t          out_item
);

  localparam int IDX_W   = $clog2(RING_DEGREE);
  localparam int STORE_W = (COEFF_BITS < nmm_pkg::VALUE_W) ? COEFF_BITS : nmm_pkg::VALUE_W;
  localparam int VW      = nmm_pkg::VALUE_W;
  localparam int OW      = nmm_pkg::IN_IDX_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_RED   = 5'b00100,
    ST_TERM  = 5'b01000,
    ST_OUT   = 5'b10000
  } back_state_t;

  back_state_t         state_r;
  back_state_t         state_nxt;
  logic [IDX_W-1:0]    idx_r;
  logic                neg_r;
  logic                sel_r;
  logic                run_r;
  logic [VW-1:0]       x_r;
  logic [VW-1:0]       y_r;
  logic [VW-1:0]       t_r;
  logic                out_valid_r;
  nmm_pkg::out_item_t  out_item_r;

  logic                take;
  logic                ram_we;
  logic [STORE_W-1:0]  rdata_a;
  logic [STORE_W-1:0]  rdata_b;
  logic [VW+STORE_W-1:0] rdata_a_wide;
  logic [VW+STORE_W-1:0] rdata_b_wide;
  logic [VW-1:0]       cur;
  logic                cur_big;
  logic                rem_start;
  logic                rem_busy;
  logic                rem_done;
  logic [VW-1:0]       rem_result;
  logic                advance;
  logic                out_free;
  logic [VW:0]         diff;
  logic [VW-1:0]       res_value;
  logic [OW+IDX_W-1:0] idx_wide;

  assign op_ready = (state_r == ST_IDLE);
  assign take     = op_valid && op_ready;
  assign ram_we   = take && !op.is_read;

  nmm_ram #(
    .WIDTH (STORE_W),
    .DEPTH (RING_DEGREE)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (op.idx),
    .wdata   (op.value),
    .raddr_a (op.pos),
    .raddr_b (op.idx),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign rdata_a_wide = {{VW{1'b0}}, rdata_a};
  assign rdata_b_wide = {{VW{1'b0}}, rdata_b};

  assign cur       = sel_r ? y_r : x_r;
  assign cur_big   = (cur >= modulus);
  assign rem_start = (state_r == ST_RED) && !run_r && !rem_busy && cur_big;

  nmm_rem #(
    .COEFF_BITS (COEFF_BITS)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (cur[STORE_W-1:0]),
    .modulus  (modulus),
    .busy     (rem_busy),
    .done     (rem_done),
    .result   (rem_result)
  );

  assign advance = (state_r == ST_RED) && ((!run_r && !cur_big) || (run_r && rem_done));

  // in minus-one mode term minus own coefficient, wrapped back into range; else the term
  assign diff      = {1'b0, t_r} - {1'b0, y_r};
  assign res_value = !minus_one ? t_r :
                     diff[VW] ? diff[VW-1:0] + modulus : diff[VW-1:0];
  assign out_free  = !out_valid_r || out_ready;
  assign idx_wide  = {{OW{1'b0}}, idx_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take && op.is_read) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_RED;
      ST_RED: begin
        if (advance && (sel_r || !minus_one)) begin
          state_nxt = ST_TERM;
        end
      end
      ST_TERM: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      run_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (rem_start) begin
        run_r <= 1'b1;
      end else if (rem_done) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      idx_r <= op.idx;
      neg_r <= op.neg;
    end
    case (state_r)
      ST_FETCH: begin
        x_r   <= rdata_a_wide[VW-1:0];
        y_r   <= rdata_b_wide[VW-1:0];
        sel_r <= 1'b0;
      end
      ST_RED: begin
        if (run_r && rem_done) begin
          if (sel_r) begin
            y_r <= rem_result;
          end else begin
            x_r <= rem_result;
          end
        end
        if (advance && !sel_r && minus_one) begin
          sel_r <= 1'b1;
        end
      end
      ST_TERM: begin
        t_r <= !neg_r ? x_r : (x_r == '0) ? '0 : modulus - x_r;
      end
      ST_OUT: begin
        if (out_free) begin
          out_item_r.result_index <= idx_wide[OW-1:0];
          out_item_r.result_value <= res_value;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `NMM_ASSERT_IMP(a_out_reduced, out_valid_r, out_item_r.result_value < modulus,
                  "result not below modulus")
  `NMM_ASSERT_IMP(a_rem_in_red, rem_done, (state_r == ST_RED) && run_r,
                  "remainder finished outside reduction")
  `NMM_ASSERT_NXT(a_fetch_after_pop, take && op.is_read, state_r == ST_FETCH,
                  "read item not fetched after pop")
  `NMM_ASSERT_IMP(a_term_reduced, state_r == ST_TERM, (x_r < modulus) && (!minus_one || y_r < modulus),
                  "operands not reduced before term")

endmodule
